FILE: rtl/ebe_sgs_pkg.sv
`timescale 1ns / 1ps

package ebe_sgs_pkg;

  localparam int IDX_W             = 12;
  localparam int DATA_W            = 32;
  localparam int VECTOR_DEPTH_DEF  = 4096;
  localparam int PADDR_W           = 3;

  localparam logic [PADDR_W-1:0] REG_NUM_EQ_ADDR  = 3'd0;
  localparam logic [IDX_W-1:0]   NUM_EQ_RESET     = 12'd4095;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_FORWARD  = 2'd1,
    KIND_BACKWARD = 2'd2,
    KIND_READ     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    NODE_A = 2'd0,
    NODE_B = 2'd1,
    NODE_C = 2'd2
  } node_t;

  typedef enum logic [1:0] {
    MUL_FIRST  = 2'd0,
    MUL_SECOND = 2'd1,
    MUL_THIRD  = 2'd2
  } mul_t;

  typedef enum logic [1:0] {
    WR_LOAD   = 2'd0,
    WR_FIRST  = 2'd1,
    WR_SECOND = 2'd2
  } wr_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SLOT_A,
    ST_SLOT_B,
    ST_SLOT_C,
    ST_GATHER_A,
    ST_GATHER_B,
    ST_GATHER_C,
    ST_CAPTURE_C,
    ST_MUL_1,
    ST_UPD_1,
    ST_MUL_2,
    ST_MUL_3,
    ST_UPD_2,
    ST_WRITE_1,
    ST_WRITE_2,
    ST_LOAD_WR,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load_in;
    node_t      slot_node;
    logic [2:0] slot_latch;
    logic       rd_en;
    node_t      rd_node;
    logic [2:0] cap;
    logic       mul_en;
    mul_t       mul_op;
    logic       upd_first;
    logic       upd_acc;
    logic       upd_last;
    logic       wr_en;
    wr_t        wr_op;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
  } status_t;

endpackage

FILE: rtl/ebe_sgs_slot.sv
`timescale 1ns / 1ps

module ebe_sgs_slot import ebe_sgs_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic [IDX_W-1:0]                idx,
  output logic [$clog2(VECTOR_DEPTH)-1:0] slot
);

  localparam int  AW     = $clog2(VECTOR_DEPTH);
  localparam bit  DIRECT = (VECTOR_DEPTH >= (1 << IDX_W)) ||
                           ((VECTOR_DEPTH & (VECTOR_DEPTH - 1)) == 0);

  logic [AW-1:0]    slot_r;

  assign slot = slot_r;

  generate
    if (DIRECT) begin : g_direct
      logic [IDX_W-1:0] idx_r;

      always_ff @(posedge clk) begin
        idx_r <= idx;
      end

      always_ff @(posedge clk) begin
        slot_r <= AW'(idx_r);
      end
    end else begin : g_recip
      // quotient estimate by reciprocal, low by at most nothing, high by at most one
      localparam int              SH    = 24;
      localparam logic [SH:0]     RECIP = (SH+1)'(((1 << SH) + VECTOR_DEPTH - 1) / VECTOR_DEPTH);
      localparam logic [IDX_W:0]  DEPTH_C = (IDX_W+1)'(VECTOR_DEPTH);

      logic [IDX_W+SH:0]     prod;
      logic [IDX_W-1:0]      quot_r;
      logic [IDX_W-1:0]      idx_d_r;
      logic [2*IDX_W+1:0]    qd;
      logic signed [IDX_W+1:0] rem;
      logic signed [IDX_W+1:0] rem_fix;

      assign prod = (IDX_W+SH+1)'(idx) * (IDX_W+SH+1)'(RECIP);

      always_ff @(posedge clk) begin
        quot_r  <= prod[IDX_W+SH-1:SH];
        idx_d_r <= idx;
      end

      assign qd      = (2*IDX_W+2)'(quot_r) * (2*IDX_W+2)'(DEPTH_C);
      assign rem     = $signed({2'b00, idx_d_r}) - $signed({1'b0, qd[IDX_W:0]});
      assign rem_fix = rem[IDX_W+1] ? rem + $signed({1'b0, DEPTH_C}) : rem;

      always_ff @(posedge clk) begin
        slot_r <= AW'(rem_fix[IDX_W-1:0]);
      end
    end
  endgenerate

endmodule

FILE: rtl/ebe_sgs_ctrl.sv
`timescale 1ns / 1ps

module ebe_sgs_ctrl import ebe_sgs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.slot_node  = NODE_A;
    cmd.rd_node    = NODE_A;
    cmd.mul_op     = MUL_FIRST;
    cmd.wr_op      = WR_LOAD;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_in = start;
        if (start) state_nxt = ST_SLOT_A;
      end
      ST_SLOT_A: begin
        cmd.slot_node = NODE_A;
        state_nxt     = ST_SLOT_B;
      end
      ST_SLOT_B: begin
        cmd.slot_node = NODE_B;
        state_nxt     = ST_SLOT_C;
      end
      ST_SLOT_C: begin
        cmd.slot_node  = NODE_C;
        cmd.slot_latch = 3'b001;
        unique case (status.kind)
          KIND_LOAD: state_nxt = ST_LOAD_WR;
          KIND_READ: state_nxt = ST_READ;
          default:   state_nxt = ST_GATHER_A;
        endcase
      end
      ST_GATHER_A: begin
        cmd.slot_latch = 3'b010;
        cmd.rd_en      = 1'b1;
        cmd.rd_node    = NODE_A;
        state_nxt      = ST_GATHER_B;
      end
      ST_GATHER_B: begin
        cmd.slot_latch = 3'b100;
        cmd.rd_en      = 1'b1;
        cmd.rd_node    = NODE_B;
        cmd.cap        = 3'b001;
        state_nxt      = ST_GATHER_C;
      end
      ST_GATHER_C: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_node = NODE_C;
        cmd.cap     = 3'b010;
        state_nxt   = ST_CAPTURE_C;
      end
      ST_CAPTURE_C: begin
        cmd.cap   = 3'b100;
        state_nxt = ST_MUL_1;
      end
      ST_MUL_1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_FIRST;
        state_nxt  = ST_UPD_1;
      end
      ST_UPD_1: begin
        cmd.upd_first = 1'b1;
        state_nxt     = ST_MUL_2;
      end
      ST_MUL_2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SECOND;
        state_nxt  = ST_MUL_3;
      end
      ST_MUL_3: begin
        cmd.upd_acc = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = MUL_THIRD;
        state_nxt   = ST_UPD_2;
      end
      ST_UPD_2: begin
        cmd.upd_last = 1'b1;
        state_nxt    = ST_WRITE_1;
      end
      ST_WRITE_1: begin
        cmd.wr_en = 1'b1;
        cmd.wr_op = WR_FIRST;
        state_nxt = ST_WRITE_2;
      end
      ST_WRITE_2: begin
        cmd.wr_en = 1'b1;
        cmd.wr_op = WR_SECOND;
        state_nxt = ST_IDLE;
      end
      ST_LOAD_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_op = WR_LOAD;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_node = NODE_A;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ebe_sgs_dpath.sv
`timescale 1ns / 1ps

module ebe_sgs_dpath import ebe_sgs_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic [IDX_W-1:0]         num_eq,
  input  logic [1:0]               in_kind,
  input  logic [IDX_W-1:0]         in_index_a,
  input  logic [IDX_W-1:0]         in_index_b,
  input  logic [IDX_W-1:0]         in_index_c,
  input  logic signed [DATA_W-1:0] in_load_value,
  input  logic signed [DATA_W-1:0] in_coef_a,
  input  logic signed [DATA_W-1:0] in_coef_b,
  input  logic signed [DATA_W-1:0] in_coef_c,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_read_index,
  output logic signed [DATA_W-1:0] out_read_value
);

  localparam int AW    = $clog2(VECTOR_DEPTH);
  localparam int PW    = 2 * DATA_W;
  localparam int TW    = PW - 16;
  localparam int ACC_W = TW + 3;

  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_W'($signed({1'b0, {(DATA_W-1){1'b1}}}))) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < ACC_W'($signed({1'b1, {(DATA_W-1){1'b0}}}))) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // latched word
  kind_t                    kind_r;
  logic [IDX_W-1:0]         idx_a_r, idx_b_r, idx_c_r;
  logic signed [DATA_W-1:0] load_value_r, coef_a_r, coef_b_r, coef_c_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r       <= kind_t'(in_kind);
      idx_a_r      <= in_index_a;
      idx_b_r      <= in_index_b;
      idx_c_r      <= in_index_c;
      load_value_r <= in_load_value;
      coef_a_r     <= in_coef_a;
      coef_b_r     <= in_coef_b;
      coef_c_r     <= in_coef_c;
    end
  end

  assign status.kind = kind_r;

  logic fwd;
  logic sink_a, sink_b, sink_c;

  assign fwd    = (kind_r == KIND_FORWARD);
  assign sink_a = (idx_a_r == num_eq);
  assign sink_b = (idx_b_r == num_eq);
  assign sink_c = (idx_c_r == num_eq);

  // address reduction
  logic [IDX_W-1:0] slot_in;
  logic [AW-1:0]    slot_out;
  logic [AW-1:0]    slot_a_r, slot_b_r, slot_c_r;

  always_comb begin
    unique case (cmd.slot_node)
      NODE_A:  slot_in = idx_a_r;
      NODE_B:  slot_in = idx_b_r;
      NODE_C:  slot_in = idx_c_r;
      default: slot_in = idx_a_r;
    endcase
  end

  ebe_sgs_slot #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_slot (
    .clk  (clk),
    .idx  (slot_in),
    .slot (slot_out)
  );

  always_ff @(posedge clk) begin
    if (cmd.slot_latch[0]) slot_a_r <= slot_out;
    if (cmd.slot_latch[1]) slot_b_r <= slot_out;
    if (cmd.slot_latch[2]) slot_c_r <= slot_out;
  end

  // working values
  logic signed [DATA_W-1:0] z0_r, z1_r, z2_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [TW-1:0]     term;
  logic signed [ACC_W-1:0]  upd1_sum, acc_in, last_sum;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] upd1_val, last_val;

  // floor of the Q16.16 product
  assign term = prod_r[PW-1:16];

  assign target   = fwd ? z2_r : z0_r;
  assign upd1_sum = ACC_W'(z1_r) - ACC_W'(term);
  assign acc_in   = ACC_W'(target) - ACC_W'(term);
  assign last_sum = acc_r - ACC_W'(term);
  assign upd1_val = sat_word(upd1_sum);
  assign last_val = sat_word(last_sum);

  // vector store
  logic [DATA_W-1:0] vec_mem_r [VECTOR_DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_sink;

  always_comb begin
    unique case (cmd.rd_node)
      NODE_A:  rd_addr = slot_a_r;
      NODE_B:  rd_addr = slot_b_r;
      NODE_C:  rd_addr = slot_c_r;
      default: rd_addr = slot_a_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_op)
      WR_LOAD: begin
        wr_addr = slot_a_r;
        wr_data = load_value_r;
        wr_sink = sink_a;
      end
      WR_FIRST: begin
        wr_addr = fwd ? slot_b_r : slot_a_r;
        wr_data = fwd ? z1_r : z0_r;
        wr_sink = fwd ? sink_b : sink_a;
      end
      WR_SECOND: begin
        wr_addr = fwd ? slot_c_r : slot_b_r;
        wr_data = fwd ? z2_r : z1_r;
        wr_sink = fwd ? sink_c : sink_b;
      end
      default: begin
        wr_addr = slot_a_r;
        wr_data = load_value_r;
        wr_sink = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && !wr_sink) begin
      vec_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= vec_mem_r[rd_addr];
    end
  end

  // gather and update
  always_ff @(posedge clk) begin
    if (cmd.cap[0]) begin
      z0_r <= sink_a ? '0 : rdata_r;
    end else if (cmd.upd_last && !fwd) begin
      z0_r <= last_val;
    end
    if (cmd.cap[1]) begin
      z1_r <= sink_b ? '0 : rdata_r;
    end else if (cmd.upd_first) begin
      z1_r <= upd1_val;
    end
    if (cmd.cap[2]) begin
      z2_r <= sink_c ? '0 : rdata_r;
    end else if (cmd.upd_last && fwd) begin
      z2_r <= last_val;
    end
    if (cmd.upd_acc) begin
      acc_r <= acc_in;
    end
  end

  // shared multiplier
  logic signed [DATA_W-1:0] mul_x, mul_y;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_FIRST: begin
        mul_x = coef_a_r;
        mul_y = fwd ? z0_r : z2_r;
      end
      MUL_SECOND: begin
        mul_x = coef_b_r;
        mul_y = fwd ? z0_r : z1_r;
      end
      MUL_THIRD: begin
        mul_x = coef_c_r;
        mul_y = fwd ? z1_r : z2_r;
      end
      default: begin
        mul_x = coef_a_r;
        mul_y = z0_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PW'(mul_x) * PW'(mul_y);
    end
  end

  // result word
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_index_r;
  logic signed [DATA_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index_r <= idx_a_r;
      out_value_r <= sink_a ? '0 : rdata_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_index = out_index_r;
  assign out_read_value = out_value_r;

endmodule

FILE: rtl/ebe_sgs_triangular_sweep.sv
`timescale 1ns / 1ps

// Triangular sweep engine over a Q16.16 vector store, one word per command.
// Input: drive the in_ ports and raise start; the word is taken at a rising
// edge with start high and busy low. busy stays high until the word is done.
// Kinds: load an entry, forward element step, backward element step, read.
// The element step is serialized by the single vector memory port (three
//   gathers, two write-backs) and the one shared 32x32 multiplier used three
//   times in sequence.
// A read gives one result word on out_read_index / out_read_value, marked by
// out_valid for exactly one cycle, registered from the EMIT state. Other kinds
// give no result. The receiver cannot stall; out_valid is never held.
// The sink index (num_equations, APB register at byte address 0, reset 4095)
// reads as zero and drops writes. Write it only while busy is low.
// Reset (rst_n low, synchronous) returns the controller to idle and sets
// num_equations to 4095; the vector store is undefined until loaded.

module ebe_sgs_triangular_sweep import ebe_sgs_pkg::*; #(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_kind,
  input  logic [IDX_W-1:0]         in_index_a,
  input  logic [IDX_W-1:0]         in_index_b,
  input  logic [IDX_W-1:0]         in_index_c,
  input  logic signed [DATA_W-1:0] in_load_value,
  input  logic signed [DATA_W-1:0] in_coef_a,
  input  logic signed [DATA_W-1:0] in_coef_b,
  input  logic signed [DATA_W-1:0] in_coef_c,
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_read_index,
  output logic signed [DATA_W-1:0] out_read_value,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [IDX_W-1:0] num_eq_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_NUM_EQ_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_eq_r <= NUM_EQ_RESET;
    end else if (cfg_wr) begin
      num_eq_r <= pwdata[IDX_W-1:0];
    end
  end

  assign prdata = (paddr == REG_NUM_EQ_ADDR) ? {{(32-IDX_W){1'b0}}, num_eq_r} : 32'd0;

  cmd_t    cmd;
  status_t status;

  ebe_sgs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  ebe_sgs_dpath #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .num_eq         (num_eq_r),
    .in_kind        (in_kind),
    .in_index_a     (in_index_a),
    .in_index_b     (in_index_b),
    .in_index_c     (in_index_c),
    .in_load_value  (in_load_value),
    .in_coef_a      (in_coef_a),
    .in_coef_b      (in_coef_b),
    .in_coef_c      (in_coef_c),
    .out_valid      (out_valid),
    .out_read_index (out_read_index),
    .out_read_value (out_read_value)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.emit))
    else $error("result strobe without an emit command");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !cmd.rd_en && !cmd.load_in)
    else $error("memory write overlaps a read or a new word");

endmodule

FILE: tb/ebe_sgs_triangular_sweep_tb.sv
`timescale 1ns / 1ps

module ebe_sgs_triangular_sweep_tb;
  import ebe_sgs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int WINDOW = 16;
  localparam int RANDOM_WORDS = 134;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
  } read_word_t;

  typedef struct {
    kind_t             kind;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  c;
    logic [DATA_W-1:0] lv;
    logic [DATA_W-1:0] ca;
    logic [DATA_W-1:0] cb;
    logic [DATA_W-1:0] cc;
  } sweep_word_t;

  class sweep_scoreboard;
    int               vec[VECTOR_DEPTH_DEF];
    bit               loaded[VECTOR_DEPTH_DEF];
    logic [IDX_W-1:0] sink;
    read_word_t       pending_reads[$];
    int               errors;
    int               words_taken;
    int               reads_checked;

    function new();
      sink = NUM_EQ_RESET;
    endfunction

    function longint gather(logic [IDX_W-1:0] i);
      if (i == sink) return 0;
      return longint'(vec[i]);
    endfunction

    function void put(logic [IDX_W-1:0] i, longint v);
      if (i != sink) begin
        vec[i] = int'(v);
        loaded[i] = 1'b1;
      end
    endfunction

    // q16.16 product, floor of the exact product
    function longint qprod(longint x, longint y);
      return (x * y) >>> 16;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_word(kind_t k, logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                            logic [IDX_W-1:0] ic, int lv, int ca, int cb, int cc);
      longint z0, z1, z2;
      read_word_t w;
      words_taken++;
      z0 = gather(ia);
      z1 = gather(ib);
      z2 = gather(ic);
      case (k)
        KIND_LOAD: put(ia, lv);
        KIND_FORWARD: begin
          z1 = clamp(z1 - qprod(ca, z0));
          z2 = clamp(z2 - qprod(cb, z0) - qprod(cc, z1));
          put(ib, z1);
          put(ic, z2);
        end
        KIND_BACKWARD: begin
          z1 = clamp(z1 - qprod(ca, z2));
          z0 = clamp(z0 - qprod(cb, z1) - qprod(cc, z2));
          put(ia, z0);
          put(ib, z1);
        end
        default: begin
          w.idx = ia;
          w.val = z0[31:0];
          pending_reads.push_back(w);
        end
      endcase
    endfunction

    function void check_read(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      read_word_t w;
      if (pending_reads.size() == 0) begin
        errors++;
        $display("%0t: unexpected read word, index %0d value %h", $time, idx, val);
        return;
      end
      w = pending_reads.pop_front();
      reads_checked++;
      if (idx !== w.idx) begin
        errors++;
        $display("%0t: read index expected %0d actual %0d", $time, w.idx, idx);
      end
      if (val !== w.val) begin
        errors++;
        $display("%0t: read value at %0d expected %h actual %h", $time, w.idx, w.val, val);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_kind = KIND_LOAD;
  logic [IDX_W-1:0]         in_index_a = '0;
  logic [IDX_W-1:0]         in_index_b = '0;
  logic [IDX_W-1:0]         in_index_c = '0;
  logic signed [DATA_W-1:0] in_load_value = '0;
  logic signed [DATA_W-1:0] in_coef_a = '0;
  logic signed [DATA_W-1:0] in_coef_b = '0;
  logic signed [DATA_W-1:0] in_coef_c = '0;
  logic                     out_valid;
  logic [IDX_W-1:0]         out_read_index;
  logic signed [DATA_W-1:0] out_read_value;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  sweep_scoreboard sb = new();
  int cycles = 0;
  int sink_settings = 0;

  ebe_sgs_triangular_sweep dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_index_a(in_index_a), .in_index_b(in_index_b),
    .in_index_c(in_index_c), .in_load_value(in_load_value),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_read_index(out_read_index),
    .out_read_value(out_read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("ebe_sgs_triangular_sweep_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_read(out_read_index, out_read_value);
  end

  function automatic logic [DATA_W-1:0] rand_q();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(0, 32'h40000) - 32'h20000;
    endcase
  endfunction

  function automatic sweep_word_t word_of(kind_t k, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                          logic [IDX_W-1:0] c, logic [DATA_W-1:0] lv,
                                          logic [DATA_W-1:0] ca, logic [DATA_W-1:0] cb,
                                          logic [DATA_W-1:0] cc);
    sweep_word_t w;
    w.kind = k;
    w.a = a;
    w.b = b;
    w.c = c;
    w.lv = lv;
    w.ca = ca;
    w.cb = cb;
    w.cc = cc;
    return w;
  endfunction

  // a node that is safe to gather: loaded already, or the sink
  function automatic logic [IDX_W-1:0] pick_node(logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] i;
    if ($urandom_range(0, 9) == 0) return sb.sink;
    repeat (32) begin
      i = base + IDX_W'($urandom_range(0, WINDOW - 1));
      if (sb.loaded[i] || i == sb.sink) return i;
    end
    return sb.sink;
  endfunction

  function automatic sweep_word_t make_word(logic [IDX_W-1:0] base);
    sweep_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w = word_of(KIND_READ, pick_node(base), pick_node(base), pick_node(base),
                rand_q(), rand_q(), rand_q(), rand_q());
    if (r < 20) begin
      w.kind = KIND_LOAD;
      w.a = ($urandom_range(0, 9) == 0) ? sb.sink :
            base + IDX_W'($urandom_range(0, WINDOW - 1));
      w.b = IDX_W'($urandom_range(0, 4095));
      w.c = IDX_W'($urandom_range(0, 4095));
    end else if (r < 55) begin
      w.kind = KIND_FORWARD;
    end else if (r < 85) begin
      w.kind = KIND_BACKWARD;
    end
    return w;
  endfunction

  task automatic send_word(sweep_word_t w);
    @(negedge clk);
    start = 1'b1;
    in_kind = w.kind;
    in_index_a = w.a;
    in_index_b = w.b;
    in_index_c = w.c;
    in_load_value = w.lv;
    in_coef_a = w.ca;
    in_coef_b = w.cb;
    in_coef_c = w.cc;
    do @(posedge clk); while (busy);
    sb.note_word(w.kind, w.a, w.b, w.c, w.lv, w.ca, w.cb, w.cc);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // wait until every read word is back and the engine is idle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_reads.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, logic [31:0] d, output logic [31:0] q);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = REG_NUM_EQ_ADDR;
    pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    q = prdata;
  endtask

  task automatic set_sink(logic [IDX_W-1:0] n);
    logic [31:0] q;
    cfg_access(1'b1, {20'd0, n}, q);
    sb.sink = n;
    cfg_access(1'b0, 32'd0, q);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sink_settings++;
    if (q[IDX_W-1:0] !== n) begin
      sb.errors++;
      $display("%0t: num_equations read expected %0d actual %0d", $time, n, q[IDX_W-1:0]);
    end
  endtask

  initial begin
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] sink_n;
    int burst_left;
    burst_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          sink_n = 4095;
          base = 4080;
        end
        1: begin
          sink_n = 1;
          base = 0;
        end
        2: begin
          base = IDX_W'($urandom_range(0, 4080));
          sink_n = IDX_W'($urandom_range(2, 4094));
        end
        3: begin
          sink_n = 2048;
          base = 2040;
        end
        default: begin
          base = IDX_W'($urandom_range(16, 4080));
          sink_n = base + IDX_W'($urandom_range(0, WINDOW - 1));
        end
      endcase
      drain();
      set_sink(sink_n);

      if (ph == 0) begin
        send_word(word_of(KIND_LOAD, 0, 7, 9, 32'h7fff_ffff, 0, 0, 0));
        send_word(word_of(KIND_LOAD, 4094, 0, 0, 32'h8000_0000, 0, 0, 0));
        send_word(word_of(KIND_LOAD, 1, 0, 0, 32'h0001_0000, 0, 0, 0));
        send_word(word_of(KIND_LOAD, 2, 0, 0, 32'hffff_ffff, 0, 0, 0));
        // load into the sink is dropped
        send_word(word_of(KIND_LOAD, 4095, 0, 0, 32'h1234_5678, 0, 0, 0));
        send_word(word_of(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
        send_word(word_of(KIND_READ, 4094, 0, 0, 0, 0, 0, 0));
        send_word(word_of(KIND_READ, 4095, 0, 0, 0, 0, 0, 0));
        // saturating forward step
        send_word(word_of(KIND_FORWARD, 0, 1, 2, 0, 32'h7fff_ffff, 32'h8000_0000,
                          32'h0001_0000));
        send_word(word_of(KIND_READ, 1, 0, 0, 0, 0, 0, 0));
        send_word(word_of(KIND_READ, 2, 0, 0, 0, 0, 0, 0));
        // sink as gathered and as written node
        send_word(word_of(KIND_FORWARD, 4095, 1, 4095, 0, 32'h0003_8000, 32'hfffe_0000,
                          32'h0000_4000));
        // both written nodes the same, second write wins
        send_word(word_of(KIND_FORWARD, 0, 2, 2, 0, 32'h0000_8000, 32'h8000_0000,
                          32'h8000_0000));
        send_word(word_of(KIND_BACKWARD, 1, 1, 2, 0, 32'h8000_0000, 32'h8000_0000,
                          32'h7fff_ffff));
        send_word(word_of(KIND_BACKWARD, 4094, 0, 4095, 0, 32'hffff_0000, 32'h0002_0000,
                          32'h7fff_ffff));
        send_word(word_of(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
        send_word(word_of(KIND_READ, 1, 0, 0, 0, 0, 0, 0));
        send_word(word_of(KIND_READ, 2, 0, 0, 0, 0, 0, 0));
        send_word(word_of(KIND_READ, 4094, 0, 0, 0, 0, 0, 0));
        send_word(word_of(KIND_LOAD, 2, 0, 0, 32'h0000_0000, 0, 0, 0));
        send_word(word_of(KIND_BACKWARD, 0, 1, 2, 0, 32'h0000_0000, 32'h0000_0000,
                          32'h0000_0000));
        send_word(word_of(KIND_READ, 0, 0, 0, 0, 0, 0, 0));
      end

      // fill the window so that element steps have real data to work on
      for (int i = 0; i < WINDOW; i++) begin
        send_word(word_of(KIND_LOAD, base + IDX_W'(i), IDX_W'($urandom_range(0, 4095)),
                          IDX_W'($urandom_range(0, 4095)), rand_q(), rand_q(), rand_q(),
                          rand_q()));
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
        if (ph != 2 && burst_left == 0) begin
          pause_sender($urandom_range(1, 10));
          burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        send_word(make_word(base));
      end
    end

    drain();
    $display("%0d words taken over %0d sink settings, %0d read words checked",
             sb.words_taken, sink_settings, sb.reads_checked);
    $display("loads, forward and backward element steps and reads, with sink and repeated nodes");
    if (sb.errors == 0) begin
      $display("ebe_sgs_triangular_sweep_tb passed");
    end else begin
      $display("ebe_sgs_triangular_sweep_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ebe_sgs_pkg.sv
rtl/ebe_sgs_slot.sv
rtl/ebe_sgs_ctrl.sv
rtl/ebe_sgs_dpath.sv
rtl/ebe_sgs_triangular_sweep.sv
tb/ebe_sgs_triangular_sweep_tb.sv
